FILE: rtl/core/call_depth_cost_profiler_unit_assert.svh
// Assertion macros for the call-depth cost profiler.
`ifndef CALL_DEPTH_COST_PROFILER_UNIT_ASSERT_SVH
`define CALL_DEPTH_COST_PROFILER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CDCP_ASSERT_IMPL(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
        else $error("cdcp assertion failed");

// Next-cycle implication, disabled in reset.
`define CDCP_ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
        else $error("cdcp assertion failed");

`endif

FILE: rtl/core/cdcp_pkg.sv
// Types and constants shared by the call-depth cost profiler.
`timescale 1ns / 1ps
package cdcp_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int IDX_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W       = 64;
    localparam int DEPTH_W      = 6;
    localparam int OVF_W        = 32;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int LIM_W        = ((CNT_W > DEPTH_W) ? CNT_W : DEPTH_W) + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int Q_FILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic               TRACE_EN_RST  = 1'b1;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = DEPTH_W'(3);
    localparam logic [DATA_W-1:0]  MIN_COST_RST  = DATA_W'(1000);
    localparam logic [OVF_W-1:0]   OVF_MAX       = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CALL   = 2'd0,
        CMD_RETURN = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_FLUSH
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACE_EN  = 2'd0,
        CFG_MAX_DEPTH = 2'd1,
        CFG_MIN_COST  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] class_id;
        logic [DATA_W-1:0] selector_id;
        logic [DATA_W-1:0] timestamp;
        logic              super_call;
    } op_item_t;

    typedef struct packed {
        back_state_t      state;
        logic [CNT_W-1:0] entry_count;
    } back_status_t;

endpackage

FILE: rtl/core/cdcp_if.sv
// Event and record channel interfaces of the call-depth cost profiler.
`timescale 1ns / 1ps
interface cdcp_evt_if;
    import cdcp_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [DATA_W-1:0]  class_id;
    logic [DATA_W-1:0]  selector_id;
    logic [DATA_W-1:0]  timestamp;
    logic               super_call;
    logic               from_main;

    modport source (output valid, command, class_id, selector_id, timestamp,
                    super_call, from_main, input ready);
    modport sink   (input valid, command, class_id, selector_id, timestamp,
                    super_call, from_main, output ready);
endinterface

interface cdcp_rec_if;
    import cdcp_pkg::*;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  rec_class;
    logic [DATA_W-1:0]  rec_selector;
    logic [DEPTH_W-1:0] rec_depth;
    logic [DATA_W-1:0]  rec_cost;
    logic               rec_super;

    modport source (output valid, rec_class, rec_selector, rec_depth, rec_cost,
                    rec_super, input ready);
    modport sink   (input valid, rec_class, rec_selector, rec_depth, rec_cost,
                    rec_super, output ready);
endinterface

FILE: rtl/core/cdcp_front.sv
// Front end: accepts events, filters and classifies them, queues operations.
`timescale 1ns / 1ps
module cdcp_front (
    input  logic             clk,
    input  logic             rst_n,
    cdcp_evt_if.sink         evt,
    input  logic             trace_enable,
    output cdcp_pkg::op_item_t q_item,
    output logic             q_valid,
    input  logic             q_ready
);
    import cdcp_pkg::*;

    op_item_t              q_mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_FILL_W-1:0]   fill_reg, fill_next;
    op_item_t              item;
    cmd_t                  cmd;
    logic                  active;
    logic                  keep;
    logic                  enq;
    logic                  deq;

    assign evt.ready = (fill_reg != Q_FILL_W'(QUEUE_DEPTH));
    assign q_valid   = (fill_reg != '0);
    assign q_item    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cmd              = cmd_t'(evt.command);
        active           = trace_enable && evt.from_main;
        item.class_id    = evt.class_id;
        item.selector_id = evt.selector_id;
        item.timestamp   = evt.timestamp;
        item.super_call  = evt.super_call;
        item.op          = OP_FLUSH;
        keep             = 1'b0;
        unique case (cmd)
            CMD_CALL:
            begin
                item.op = OP_PUSH;
                keep    = active;
            end
            CMD_RETURN:
            begin
                item.op = OP_POP;
                keep    = active;
            end
            CMD_FLUSH:
            begin
                item.op = OP_FLUSH;
                keep    = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        enq         = evt.valid && evt.ready && keep;
        deq         = q_valid && q_ready;
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (enq && !deq)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: rtl/core/cdcp_back.sv
// Back end: call stack memory, overflow counter, cost check and record register.
`timescale 1ns / 1ps
module cdcp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cdcp_pkg::op_item_t           q_item,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [cdcp_pkg::DEPTH_W-1:0] max_depth,
    input  logic [cdcp_pkg::DATA_W-1:0]  min_cost,
    cdcp_rec_if.source                   rec,
    output cdcp_pkg::back_status_t       status
);
    import cdcp_pkg::*;

    localparam int ENTRY_W = 3 * DATA_W;

    logic [ENTRY_W-1:0]  stack_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [ENTRY_W-1:0]  wr_data;
    logic                mem_we;
    logic                mem_re;
    logic [IDX_W-1:0]    wr_idx;
    logic [IDX_W-1:0]    rd_idx;

    back_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OVF_W-1:0]    ovf_reg, ovf_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DATA_W-1:0]   ts_reg, ts_next;
    logic                super_reg, super_next;
    logic [DATA_W-1:0]   cost_reg, cost_next;
    logic                rec_valid_reg, rec_valid_next;
    logic [DATA_W-1:0]   rec_class_reg;
    logic [DATA_W-1:0]   rec_selector_reg;
    logic [DEPTH_W-1:0]  rec_depth_reg;
    logic [DATA_W-1:0]   rec_cost_reg;
    logic                rec_super_reg;
    logic                rec_load;
    logic                stack_full;
    logic [CNT_W-1:0]    top;

    // entry layout: class, selector, start time
    assign wr_data = {q_item.class_id, q_item.selector_id, q_item.timestamp};
    assign top     = count_reg - 1'b1;

    assign rec.valid        = rec_valid_reg;
    assign rec.rec_class    = rec_class_reg;
    assign rec.rec_selector = rec_selector_reg;
    assign rec.rec_depth    = rec_depth_reg;
    assign rec.rec_cost     = rec_cost_reg;
    assign rec.rec_super    = rec_super_reg;

    assign status.state       = state_reg;
    assign status.entry_count = count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        ts_next        = ts_reg;
        super_next     = super_reg;
        cost_next      = cost_reg;
        rec_load       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_idx         = count_reg[IDX_W-1:0];
        rd_idx         = top[IDX_W-1:0];
        q_ready        = 1'b0;
        stack_full     = (LIM_W'(count_reg) > LIM_W'(max_depth))
                      || (count_reg == CNT_W'(STACK_DEPTH));

        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    unique case (q_item.op)
                        OP_PUSH:
                        begin
                            if (stack_full)
                            begin
                                if (ovf_reg != OVF_MAX)
                                begin
                                    ovf_next = ovf_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (ovf_reg != '0)
                            begin
                                ovf_next = ovf_reg - 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                idx_next   = top[IDX_W-1:0];
                                count_next = top;
                                ts_next    = q_item.timestamp;
                                super_next = q_item.super_call;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            ovf_next   = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cost_next  = ts_reg - rd_data_reg[DATA_W-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (cost_reg >= min_cost) ? ST_EMIT : ST_IDLE;
            end
            default:
            begin
                if (!rec_valid_reg || rec.ready)
                begin
                    rec_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (rec_load)
        begin
            rec_valid_next = 1'b1;
        end
        else if (rec.ready)
        begin
            rec_valid_next = 1'b0;
        end
        else
        begin
            rec_valid_next = rec_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        ts_reg    <= ts_next;
        super_reg <= super_next;
        cost_reg  <= cost_next;
        if (rec_load)
        begin
            rec_class_reg    <= rd_data_reg[3*DATA_W-1:2*DATA_W];
            rec_selector_reg <= rd_data_reg[2*DATA_W-1:DATA_W];
            rec_depth_reg    <= DEPTH_W'(idx_reg);
            rec_cost_reg     <= cost_reg;
            rec_super_reg    <= super_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_idx] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[rd_idx];
        end
    end

endmodule

FILE: rtl/core/call_depth_cost_profiler_unit.sv
// Call-depth cost profiler: the back end does a call, flush or overflowed return while idle.
// A return that pops goes on to stack read, 64-bit subtract and min_cost compare, then
// loads the record register if cost >= min_cost; it waits there while the record sink stalls.
// A 2-entry operation queue decouples event intake from the stack engine.
// Reset (rst_n, async, active low) empties stack and queue, clears the overflow count and
// loads trace_enable=1, max_depth=3, min_cost=1000; stack entries are not cleared.
`timescale 1ns / 1ps
`include "call_depth_cost_profiler_unit_assert.svh"
module call_depth_cost_profiler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cdcp_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [cdcp_pkg::DATA_W-1:0]    cfg_wdata,
    cdcp_evt_if.sink                       evt,
    cdcp_rec_if.source                     rec
);
    import cdcp_pkg::*;

    logic                trace_en_reg;
    logic [DEPTH_W-1:0]  max_depth_reg;
    logic [DATA_W-1:0]   min_cost_reg;
    op_item_t            q_item;
    logic                q_valid;
    logic                q_ready;
    back_status_t        back_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_en_reg  <= TRACE_EN_RST;
            max_depth_reg <= MAX_DEPTH_RST;
            min_cost_reg  <= MIN_COST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_TRACE_EN:  trace_en_reg  <= cfg_wdata[0];
                CFG_MAX_DEPTH: max_depth_reg <= cfg_wdata[DEPTH_W-1:0];
                CFG_MIN_COST:  min_cost_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    cdcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .trace_enable (trace_en_reg),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_ready      (q_ready)
    );

    cdcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .max_depth (max_depth_reg),
        .min_cost  (min_cost_reg),
        .rec       (rec),
        .status    (back_status)
    );

    `CDCP_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, back_status.entry_count <= CNT_W'(STACK_DEPTH))
    `CDCP_ASSERT_NEXT(a_emit_loads, clk, rst_n, (back_status.state == ST_EMIT) && rec.ready, rec.valid)
    `CDCP_ASSERT_IMPL(a_rec_source, clk, rst_n, $rose(rec.valid), $past(back_status.state) == ST_EMIT)

endmodule
